// ===== design/crau_pkg.sv =====
// ----------------------------------------------------------------------------
// crau_pkg
// Shared types and constants of the claim-based resource allocator: operation
// and status codes, the fixed field widths of the channels and the control
// bundle that the evaluation logic hands back to the top level.
// ----------------------------------------------------------------------------
package crau_pkg;

  // Fixed widths of the channel and configuration fields.
  localparam int FIELD_W    = 8;
  localparam int FIELD_RES  = 4;
  localparam int CLIENT_W   = 3;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int EXT_W      = 16;
  localparam int CLIENT_EXT_W = 7;

  // Operation codes of an input item.
  typedef enum logic [REQ_W-1:0] {
    REQ_INIT    = 2'd0,
    REQ_DECLARE = 2'd1,
    REQ_REQUEST = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  // Outcome codes of a result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_BLOCKED       = 2'd1,
    ST_EXCEEDS_CLAIM = 2'd2,
    ST_BAD_DECLARE   = 2'd3
  } status_t;

  // Control bundle from the evaluation logic.
  typedef struct packed {
    logic    granted;
    status_t status;
    logic    row_we;
    logic    init;
  } eval_ctl_t;

endpackage

// ===== design/crau_req_if.sv =====
// ----------------------------------------------------------------------------
// crau_req_if
// Request channel: valid/ready handshake carrying one operation per transfer.
// ----------------------------------------------------------------------------
interface crau_req_if;
  logic                           valid;
  logic                           ready;
  logic [crau_pkg::REQ_W-1:0]     req_type;
  logic [crau_pkg::CLIENT_W-1:0]  client;
  logic [crau_pkg::FIELD_W-1:0]   amount_r0;
  logic [crau_pkg::FIELD_W-1:0]   amount_r1;
  logic [crau_pkg::FIELD_W-1:0]   amount_r2;
  logic [crau_pkg::FIELD_W-1:0]   amount_r3;

  modport source (
    output valid, req_type, client, amount_r0, amount_r1, amount_r2, amount_r3,
    input  ready
  );

  modport sink (
    input  valid, req_type, client, amount_r0, amount_r1, amount_r2, amount_r3,
    output ready
  );
endinterface

// ===== design/crau_rsp_if.sv =====
// ----------------------------------------------------------------------------
// crau_rsp_if
// Result channel: valid/ready handshake carrying one outcome per transfer.
// ----------------------------------------------------------------------------
interface crau_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [crau_pkg::STATUS_W-1:0]  status;
  logic [crau_pkg::FIELD_W-1:0]   free_r0;
  logic [crau_pkg::FIELD_W-1:0]   free_r1;
  logic [crau_pkg::FIELD_W-1:0]   free_r2;
  logic [crau_pkg::FIELD_W-1:0]   free_r3;

  modport source (
    output valid, granted, status, free_r0, free_r1, free_r2, free_r3,
    input  ready
  );

  modport sink (
    input  valid, granted, status, free_r0, free_r1, free_r2, free_r3,
    output ready
  );
endinterface

// ===== design/crau_eval.sv =====
// ----------------------------------------------------------------------------
// crau_eval
// Evaluates one operation against the pool and one client's claim/held row:
// admission checks per resource, the updated free counts and the updated row.
// ----------------------------------------------------------------------------
module crau_eval #(
  parameter int NUM_RESOURCES = 4,
  parameter int UNIT_WIDTH    = 8
) (
  input  crau_pkg::req_t                              op,
  input  logic                                        in_range,
  input  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    amt,
  input  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    tot,
  input  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    avail,
  input  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    claim,
  input  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    held,
  output crau_pkg::eval_ctl_t                         ctl,
  output logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    avail_nxt,
  output logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    claim_nxt,
  output logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0]    held_nxt
);

  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0] need;
  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0] avail_take;
  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0] held_give;
  logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0] avail_back;
  logic [NUM_RESOURCES-1:0][UNIT_WIDTH:0]   back_sum;
  logic [NUM_RESOURCES-1:0]                 dec_bad;
  logic [NUM_RESOURCES-1:0]                 req_bad;
  logic [NUM_RESOURCES-1:0]                 blocked;

  // Per-resource checks and candidate updates, all independent lanes.
  always_comb begin
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      need[r]       = (claim[r] > held[r]) ? (claim[r] - held[r]) : '0;
      dec_bad[r]    = (amt[r] > tot[r]) || (held[r] != '0);
      req_bad[r]    = amt[r] > need[r];
      blocked[r]    = avail[r] < need[r];
      // A granted request never takes more than is free or than the claim allows.
      avail_take[r] = avail[r] - amt[r];
      held_give[r]  = held[r] + amt[r];
      // Release saturates when the totals were raised after init.
      back_sum[r]   = {1'b0, avail[r]} + {1'b0, held[r]};
      avail_back[r] = back_sum[r][UNIT_WIDTH] ? '1 : back_sum[r][UNIT_WIDTH-1:0];
    end
  end

  // Operation decode and selection of the new state.
  always_comb begin
    ctl.granted = 1'b0;
    ctl.status  = crau_pkg::ST_OK;
    ctl.row_we  = 1'b0;
    ctl.init    = 1'b0;
    avail_nxt   = avail;
    claim_nxt   = claim;
    held_nxt    = held;
    case (op)
      crau_pkg::REQ_INIT: begin
        avail_nxt   = tot;
        ctl.granted = 1'b1;
        ctl.init    = 1'b1;
      end
      crau_pkg::REQ_DECLARE: begin
        if (!in_range || (|dec_bad)) begin
          ctl.status = crau_pkg::ST_BAD_DECLARE;
        end else begin
          claim_nxt   = amt;
          ctl.granted = 1'b1;
          ctl.row_we  = 1'b1;
        end
      end
      crau_pkg::REQ_REQUEST: begin
        if (!in_range) begin
          ctl.status = crau_pkg::ST_BAD_DECLARE;
        end else if (|req_bad) begin
          ctl.status = crau_pkg::ST_EXCEEDS_CLAIM;
        end else if (|blocked) begin
          ctl.status = crau_pkg::ST_BLOCKED;
        end else begin
          avail_nxt   = avail_take;
          held_nxt    = held_give;
          ctl.granted = 1'b1;
          ctl.row_we  = 1'b1;
        end
      end
      crau_pkg::REQ_RELEASE: begin
        if (!in_range) begin
          ctl.status = crau_pkg::ST_BAD_DECLARE;
        end else begin
          avail_nxt   = avail_back;
          held_nxt    = '0;
          ctl.granted = 1'b1;
          ctl.row_we  = 1'b1;
        end
      end
      default: begin
        ctl.status = crau_pkg::ST_BAD_DECLARE;
      end
    endcase
  end

endmodule

// ===== design/claim_based_resource_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// claim_based_resource_allocator_unit
// Pool manager for a set of clients and resource kinds with per-client claims
// and conservative admission of requests.
// ----------------------------------------------------------------------------
// The unit takes one operation per clock cycle while the result channel is not
// stalled and answers each with one result: the request is captured in an
// input register together with the client's claim/held row read from the row
// memory, and the result leaves from the output register. The row memory has a
// registered read port; a one-entry forwarding register covers an operation
// that follows a write to the same client in the next cycle. Init clears the
// per-client valid bits, so no clearing pass is needed and the unit is ready
// straight out of reset. The user must write the pool totals over the cfg port
// only while the unit is idle; the unit itself does not enforce this.
module claim_based_resource_allocator_unit #(
  parameter int NUM_CLIENTS   = 8,
  parameter int NUM_RESOURCES = 4,
  parameter int UNIT_WIDTH    = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  crau_req_if.sink                         in_chan,
  crau_rsp_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [crau_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crau_pkg::FIELD_W-1:0]     cfg_wdata
);

  localparam int CLW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam logic [crau_pkg::CLIENT_EXT_W-1:0] CLIENT_LIMIT =
    crau_pkg::CLIENT_EXT_W'(NUM_CLIENTS);

  typedef logic [NUM_RESOURCES-1:0][UNIT_WIDTH-1:0] units_t;

  typedef struct packed {
    units_t claim;
    units_t held;
  } row_t;

  // Configuration and pool state.
  units_t                total_r;
  units_t                avail_r;
  logic [NUM_CLIENTS-1:0] row_valid_r;

  // Row memory and forwarding register.
  row_t                  row_mem [NUM_CLIENTS];
  row_t                  rd_row_r;
  row_t                  byp_row_r;
  logic [CLW-1:0]        byp_idx_r;
  logic                  byp_valid_r;

  // Input register.
  logic                  s1_valid_r;
  crau_pkg::req_t        s1_op_r;
  logic                  s1_in_range_r;
  logic [CLW-1:0]        s1_idx_r;
  units_t                s1_amt_r;

  // Output register.
  logic                  out_valid_r;
  logic                  res_granted_r;
  crau_pkg::status_t     res_status_r;
  logic [crau_pkg::FIELD_RES-1:0][crau_pkg::FIELD_W-1:0] res_free_r;

  // Handshake and decode signals.
  logic                  adv;
  logic                  fire;
  logic                  in_fire;
  logic [crau_pkg::CLIENT_EXT_W-1:0] in_client_ext;
  logic                  in_range;
  logic [CLW-1:0]        in_idx;
  units_t                in_amt;
  logic [crau_pkg::FIELD_RES-1:0][crau_pkg::FIELD_W-1:0] in_amt_fld;

  row_t                  cur_row;
  row_t                  new_row;
  crau_pkg::eval_ctl_t   ctl;
  units_t                avail_nxt;
  units_t                claim_nxt;
  units_t                held_nxt;
  logic [crau_pkg::FIELD_RES-1:0][crau_pkg::FIELD_W-1:0] free_fld;

  // Handshake: the input register moves on whenever the output register frees up.
  assign adv           = !out_valid_r || out_chan.ready;
  assign fire          = s1_valid_r && adv;
  assign in_chan.ready = !s1_valid_r || adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Client decode and amount masking to the unit width.
  assign in_client_ext = crau_pkg::CLIENT_EXT_W'(in_chan.client);
  assign in_range      = in_client_ext < CLIENT_LIMIT;
  assign in_idx        = in_client_ext[CLW-1:0];
  assign in_amt_fld[0] = in_chan.amount_r0;
  assign in_amt_fld[1] = in_chan.amount_r1;
  assign in_amt_fld[2] = in_chan.amount_r2;
  assign in_amt_fld[3] = in_chan.amount_r3;

  always_comb begin
    logic [crau_pkg::EXT_W-1:0] wide;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      wide      = crau_pkg::EXT_W'(in_amt_fld[r]);
      in_amt[r] = wide[UNIT_WIDTH-1:0];
    end
  end

  // Configuration writes of the pool totals.
  always_ff @(posedge clk) begin
    logic [crau_pkg::EXT_W-1:0] wide;
    wide = crau_pkg::EXT_W'(cfg_wdata);
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_we) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        if (cfg_index == crau_pkg::CFG_IDX_W'(r)) begin
          total_r[r] <= wide[UNIT_WIDTH-1:0];
        end
      end
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r       <= crau_pkg::req_t'(in_chan.req_type);
      s1_in_range_r <= in_range;
      s1_idx_r      <= in_idx;
      s1_amt_r      <= in_amt;
    end
  end

  // Row memory: read on the request transfer, write when an operation retires.
  always_ff @(posedge clk) begin
    if (in_fire && in_range) begin
      rd_row_r <= row_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.row_we) begin
      row_mem[s1_idx_r] <= new_row;
    end
  end

  // Current row: forwarded write first, then the memory if the row is valid.
  always_comb begin
    if (byp_valid_r && (byp_idx_r == s1_idx_r)) begin
      cur_row = byp_row_r;
    end else if (s1_in_range_r && row_valid_r[s1_idx_r]) begin
      cur_row = rd_row_r;
    end else begin
      cur_row = '0;
    end
  end

  crau_eval #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .UNIT_WIDTH    (UNIT_WIDTH)
  ) u_eval (
    .op        (s1_op_r),
    .in_range  (s1_in_range_r),
    .amt       (s1_amt_r),
    .tot       (total_r),
    .avail     (avail_r),
    .claim     (cur_row.claim),
    .held      (cur_row.held),
    .ctl       (ctl),
    .avail_nxt (avail_nxt),
    .claim_nxt (claim_nxt),
    .held_nxt  (held_nxt)
  );

  assign new_row.claim = claim_nxt;
  assign new_row.held  = held_nxt;

  // Free counts shown on the result; absent resources read as zero.
  always_comb begin
    logic [crau_pkg::EXT_W-1:0] wide;
    free_fld = '0;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      wide        = crau_pkg::EXT_W'(avail_nxt[r]);
      free_fld[r] = wide[crau_pkg::FIELD_W-1:0];
    end
  end

  // Pool state, row valid bits and forwarding control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r     <= '0;
      row_valid_r <= '0;
      byp_valid_r <= 1'b0;
    end else if (fire) begin
      avail_r <= avail_nxt;
      if (ctl.init) begin
        row_valid_r <= '0;
        byp_valid_r <= 1'b0;
      end else if (ctl.row_we) begin
        row_valid_r[s1_idx_r] <= 1'b1;
        byp_valid_r           <= 1'b1;
      end
    end
  end

  // Forwarding register payload.
  always_ff @(posedge clk) begin
    if (fire && ctl.row_we) begin
      byp_idx_r <= s1_idx_r;
      byp_row_r <= new_row;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      res_granted_r <= ctl.granted;
      res_status_r  <= ctl.status;
      res_free_r    <= free_fld;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.granted = res_granted_r;
  assign out_chan.status  = res_status_r;
  assign out_chan.free_r0 = res_free_r[0];
  assign out_chan.free_r1 = res_free_r[1];
  assign out_chan.free_r2 = res_free_r[2];
  assign out_chan.free_r3 = res_free_r[3];

  // The request side is open whenever the result side is not stalled.
  a_ready_when_flowing: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_chan.ready) |-> in_chan.ready)
    else $error("request side closed while the result side can move");

  // Init drops every client row and the forwarded write.
  a_init_clears_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (s1_op_r == crau_pkg::REQ_INIT)) |=> (row_valid_r == '0 && !byp_valid_r))
    else $error("client rows survived an init");

  // A granted operation always reports success.
  a_granted_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.granted) |-> (out_chan.status == crau_pkg::ST_OK))
    else $error("granted result with a failure status");

  // A stalled operation stays in the input register.
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("operation lost while the result side was stalled");

  // The forwarded row always belongs to a written client.
  a_forward_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    byp_valid_r |-> row_valid_r[byp_idx_r])
    else $error("forwarded row refers to an invalid client row");

endmodule

// ===== tb/sv/claim_based_resource_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// claim_based_resource_allocator_unit_tb
// Self-checking bench for the claim-based resource allocator. A directed
// table covers reset state, field extremes and every outcome code. Random
// phases under several pool totals follow, built mostly from legal declare,
// request and release sequences. Each result transfer is compared with an
// in-bench model of the pool, claims and held units.
// ----------------------------------------------------------------------------
module claim_based_resource_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CLIENTS     = 8;
  localparam int NUM_RESOURCES   = 4;
  localparam int UNIT_WIDTH      = 8;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_CYCLES     = 48;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int SENDER_PAUSE_AT = 900;
  localparam int RECV_HOLD_AT    = 1250;

  localparam logic [crau_pkg::CFG_IDX_W-1:0] TOTAL_R0_IDX = '0;
  localparam logic [crau_pkg::FIELD_W-1:0]   UNIT_MAX     =
    crau_pkg::FIELD_W'((1 << UNIT_WIDTH) - 1);

  typedef logic [crau_pkg::FIELD_RES-1:0][crau_pkg::FIELD_W-1:0] unit_vec_t;

  typedef struct packed {
    crau_pkg::req_t                  kind;
    logic [crau_pkg::CLIENT_W-1:0]   client;
    unit_vec_t                       amount;
  } alloc_op_t;

  typedef struct packed {
    logic              granted;
    crau_pkg::status_t status;
    unit_vec_t         free_units;
  } alloc_result_t;

  typedef struct packed {
    logic          is_cfg;
    logic          typed;
    alloc_op_t     op;
    alloc_result_t want;
  } dir_row_t;

  localparam unit_vec_t ZERO_UNITS = '0;
  localparam unit_vec_t FULL_UNITS = '1;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [crau_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [crau_pkg::FIELD_W-1:0]   cfg_wdata;

  crau_req_if req_if ();
  crau_rsp_if rsp_if ();

  claim_based_resource_allocator_unit #(
    .NUM_CLIENTS   (NUM_CLIENTS),
    .NUM_RESOURCES (NUM_RESOURCES),
    .UNIT_WIDTH    (UNIT_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_if),
    .out_chan  (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model of the pool: configured totals, free units, claims and holdings.
  unit_vec_t total_cfg = '0;
  unit_vec_t pool_free = '0;
  unit_vec_t claim_tbl [NUM_CLIENTS] = '{default: '0};
  unit_vec_t held_tbl  [NUM_CLIENTS] = '{default: '0};

  alloc_result_t outcome_q [$];
  dir_row_t      dir_table [$];
  logic          want_typed;
  alloc_result_t want_value;

  int  send_idle_pct = 22;
  int  recv_idle_pct = 66;
  bit  hold_asked    = 1'b0;
  int  err_cnt       = 0;
  int  sent_cnt      = 0;
  int  checked_cnt   = 0;
  int  granted_cnt   = 0;
  int  status_cnt [4] = '{default: 0};

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Applies one operation to the model and returns the outcome it reports.
  function automatic alloc_result_t pool_outcome(alloc_op_t op);
    alloc_result_t res;
    unit_vec_t     amt;
    unit_vec_t     need;
    logic          over_claim;
    logic          short_pool;
    logic          bad_decl;
    int            c;
    int            sum;
    res.granted = 1'b0;
    res.status  = crau_pkg::ST_OK;
    over_claim  = 1'b0;
    short_pool  = 1'b0;
    bad_decl    = 1'b0;
    c = int'(op.client);
    for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
      amt[r] = op.amount[r] & UNIT_MAX;
    end
    if (op.kind == crau_pkg::REQ_INIT) begin
      for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
        pool_free[r] = total_cfg[r] & UNIT_MAX;
      end
      for (int k = 0; k < NUM_CLIENTS; k++) begin
        claim_tbl[k] = '0;
        held_tbl[k]  = '0;
      end
      res.granted = 1'b1;
    end else if (c >= NUM_CLIENTS) begin
      res.status = crau_pkg::ST_BAD_DECLARE;
    end else begin
      case (op.kind)
        crau_pkg::REQ_DECLARE: begin
          // A claim may not pass the totals and may only change while empty-handed.
          for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
            if (amt[r] > (total_cfg[r] & UNIT_MAX) || held_tbl[c][r] != '0) bad_decl = 1'b1;
          end
          if (bad_decl) begin
            res.status = crau_pkg::ST_BAD_DECLARE;
          end else begin
            claim_tbl[c] = amt;
            res.granted  = 1'b1;
          end
        end
        crau_pkg::REQ_REQUEST: begin
          // The claim check comes first, then the pool must cover the whole remainder.
          for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
            need[r] = (claim_tbl[c][r] > held_tbl[c][r]) ?
                      claim_tbl[c][r] - held_tbl[c][r] : '0;
            if (amt[r] > need[r]) over_claim = 1'b1;
            if (pool_free[r] < need[r]) short_pool = 1'b1;
          end
          if (over_claim) begin
            res.status = crau_pkg::ST_EXCEEDS_CLAIM;
          end else if (short_pool) begin
            res.status = crau_pkg::ST_BLOCKED;
          end else begin
            for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
              pool_free[r]   = pool_free[r] - amt[r];
              held_tbl[c][r] = held_tbl[c][r] + amt[r];
            end
            res.granted = 1'b1;
          end
        end
        default: begin
          // Release returns every held unit; the pool saturates at the unit maximum.
          for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
            sum = int'(pool_free[r]) + int'(held_tbl[c][r]);
            pool_free[r] = (sum > int'(UNIT_MAX)) ? UNIT_MAX : crau_pkg::FIELD_W'(sum);
          end
          held_tbl[c] = '0;
          res.granted = 1'b1;
        end
      endcase
    end
    for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
      res.free_units[r] = (r < NUM_RESOURCES) ? pool_free[r] : '0;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [crau_pkg::FIELD_W-1:0] want,
                                      logic [crau_pkg::FIELD_W-1:0] act);
    if (act !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, act);
      err_cnt++;
    end
  endfunction

  // Monitor: results are checked first, then an accepted operation is predicted.
  always @(posedge clk) begin
    alloc_result_t exp_res;
    alloc_op_t     seen;
    alloc_result_t predicted;
    if (rst_n) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no outcome outstanding");
          err_cnt++;
        end else begin
          exp_res = outcome_q.pop_front();
          check_field("granted", crau_pkg::FIELD_W'(exp_res.granted),
                      crau_pkg::FIELD_W'(rsp_if.granted));
          check_field("status", crau_pkg::FIELD_W'(exp_res.status),
                      crau_pkg::FIELD_W'(rsp_if.status));
          check_field("free_r0", exp_res.free_units[0], rsp_if.free_r0);
          check_field("free_r1", exp_res.free_units[1], rsp_if.free_r1);
          check_field("free_r2", exp_res.free_units[2], rsp_if.free_r2);
          check_field("free_r3", exp_res.free_units[3], rsp_if.free_r3);
          checked_cnt++;
          if (exp_res.granted) granted_cnt++;
          status_cnt[int'(exp_res.status)]++;
        end
      end
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
        seen.kind   = crau_pkg::req_t'(req_if.req_type);
        seen.client = req_if.client;
        seen.amount = {req_if.amount_r3, req_if.amount_r2, req_if.amount_r1, req_if.amount_r0};
        predicted   = pool_outcome(seen);
        outcome_q   = {outcome_q, (want_typed ? want_value : predicted)};
        sent_cnt++;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    int  hold_left;
    logic go;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked) begin
        hold_left  = HOLD_CYCLES;
        hold_asked = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        go = 1'b0;
      end else begin
        go = ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
      rsp_if.ready <= go;
    end
  end

  // Offers one operation and returns at the falling edge after its transfer.
  task automatic send_op(alloc_op_t op, logic typed, alloc_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= op.kind;
    req_if.client    <= op.client;
    req_if.amount_r0 <= op.amount[0];
    req_if.amount_r1 <= op.amount[1];
    req_if.amount_r2 <= op.amount[2];
    req_if.amount_r3 <= op.amount[3];
    want_typed       <= typed;
    want_value       <= want;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stops offering and waits until every outcome has been seen.
  task automatic settle_pool();
    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_totals(unit_vec_t totals);
    for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
      cfg_we       <= 1'b1;
      cfg_index    <= TOTAL_R0_IDX + crau_pkg::CFG_IDX_W'(r);
      cfg_wdata    <= totals[r];
      total_cfg[r]  = totals[r];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic unit_vec_t units(int a0, int a1, int a2, int a3);
    return {crau_pkg::FIELD_W'(a3), crau_pkg::FIELD_W'(a2),
            crau_pkg::FIELD_W'(a1), crau_pkg::FIELD_W'(a0)};
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(dir_row_t row);
    dir_table = {dir_table, row};
  endfunction

  function automatic dir_row_t op_row(crau_pkg::req_t kind, int client, unit_vec_t amt);
    dir_row_t row;
    row           = '0;
    row.op.kind   = kind;
    row.op.client = crau_pkg::CLIENT_W'(client);
    row.op.amount = amt;
    return row;
  endfunction

  function automatic dir_row_t chk_row(crau_pkg::req_t kind, int client, unit_vec_t amt,
                                       logic granted, crau_pkg::status_t status,
                                       unit_vec_t free_u);
    dir_row_t row;
    row                 = op_row(kind, client, amt);
    row.typed           = 1'b1;
    row.want.granted    = granted;
    row.want.status     = status;
    row.want.free_units = free_u;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(unit_vec_t totals);
    dir_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.op.amount = totals;
    return row;
  endfunction

  // Picks an amount up to a limit, leaning toward the ends of the range.
  function automatic logic [crau_pkg::FIELD_W-1:0] share_of(
      logic [crau_pkg::FIELD_W-1:0] limit);
    int roll;
    roll = $urandom_range(7);
    if (roll == 0) return '0;
    if (roll <= 2) return limit;
    return crau_pkg::FIELD_W'($urandom_range(int'(limit)));
  endfunction

  // Draws a mostly well-formed operation from the current pool state.
  function automatic alloc_op_t draw_op();
    alloc_op_t op;
    int        roll;
    int        c;
    logic [crau_pkg::FIELD_W-1:0] need;
    roll = $urandom_range(99);
    c    = $urandom_range(NUM_CLIENTS - 1);
    op.client = crau_pkg::CLIENT_W'(c);
    for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
      op.amount[r] = crau_pkg::FIELD_W'($urandom_range(255));
    end
    if (roll < 3) begin
      op.kind = crau_pkg::REQ_INIT;
    end else if (roll < 25) begin
      op.kind = crau_pkg::REQ_DECLARE;
      if (held_tbl[c] != '0 && $urandom_range(3) != 0) begin
        op.kind = crau_pkg::REQ_RELEASE;
      end else if ($urandom_range(9) != 0) begin
        for (int r = 0; r < crau_pkg::FIELD_RES; r++) op.amount[r] = share_of(total_cfg[r]);
      end
    end else if (roll < 82) begin
      op.kind = crau_pkg::REQ_REQUEST;
      if ($urandom_range(9) != 0) begin
        for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
          need = (claim_tbl[c][r] > held_tbl[c][r]) ? claim_tbl[c][r] - held_tbl[c][r] : '0;
          op.amount[r] = share_of(need);
        end
      end
    end else begin
      op.kind = crau_pkg::REQ_RELEASE;
    end
    return op;
  endfunction

  // Main sequence: reset, directed table, random phases, end of run.
  initial begin
    unit_vec_t phase_totals;
    alloc_op_t op;
    int        rnd_idx;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= crau_pkg::REQ_INIT;
    req_if.client    <= '0;
    req_if.amount_r0 <= '0;
    req_if.amount_r1 <= '0;
    req_if.amount_r2 <= '0;
    req_if.amount_r3 <= '0;
    want_typed       <= 1'b0;
    want_value       <= '0;

    // Straight out of reset: zero totals, zero pool, zero claims.
    add_row(chk_row(crau_pkg::REQ_REQUEST, 0, ZERO_UNITS, 1'b1, crau_pkg::ST_OK, ZERO_UNITS));
    add_row(chk_row(crau_pkg::REQ_DECLARE, 1, units(1, 0, 0, 0), 1'b0,
                    crau_pkg::ST_BAD_DECLARE, ZERO_UNITS));
    add_row(chk_row(crau_pkg::REQ_RELEASE, 7, FULL_UNITS, 1'b1, crau_pkg::ST_OK, ZERO_UNITS));
    add_row(chk_row(crau_pkg::REQ_REQUEST, 2, FULL_UNITS, 1'b0,
                    crau_pkg::ST_EXCEEDS_CLAIM, ZERO_UNITS));
    // Full totals: claim everything, then contend for it.
    add_row(cfg_row(FULL_UNITS));
    add_row(chk_row(crau_pkg::REQ_INIT, 0, ZERO_UNITS, 1'b1, crau_pkg::ST_OK, FULL_UNITS));
    add_row(chk_row(crau_pkg::REQ_DECLARE, 7, FULL_UNITS, 1'b1, crau_pkg::ST_OK, FULL_UNITS));
    add_row(op_row(crau_pkg::REQ_REQUEST, 7, units(255, 0, 0, 0)));
    add_row(op_row(crau_pkg::REQ_REQUEST, 0, units(1, 0, 0, 0)));
    add_row(op_row(crau_pkg::REQ_DECLARE, 7, ZERO_UNITS));
    add_row(op_row(crau_pkg::REQ_DECLARE, 0, units(0, 255, 255, 255)));
    add_row(op_row(crau_pkg::REQ_REQUEST, 0, units(0, 1, 0, 0)));
    add_row(op_row(crau_pkg::REQ_REQUEST, 7, units(0, 255, 255, 255)));
    add_row(op_row(crau_pkg::REQ_REQUEST, 7, ZERO_UNITS));
    add_row(op_row(crau_pkg::REQ_RELEASE, 0, ZERO_UNITS));
    add_row(op_row(crau_pkg::REQ_REQUEST, 7, ZERO_UNITS));
    add_row(op_row(crau_pkg::REQ_REQUEST, 7, units(0, 255, 255, 255)));
    add_row(op_row(crau_pkg::REQ_RELEASE, 7, ZERO_UNITS));
    // Uneven totals, one of them zero.
    add_row(cfg_row(units(0, 170, 85, 1)));
    add_row(op_row(crau_pkg::REQ_DECLARE, 3, units(1, 0, 0, 0)));
    add_row(chk_row(crau_pkg::REQ_INIT, 5, FULL_UNITS, 1'b1, crau_pkg::ST_OK,
                    units(0, 170, 85, 1)));
    add_row(op_row(crau_pkg::REQ_DECLARE, 3, units(0, 170, 85, 1)));
    add_row(op_row(crau_pkg::REQ_REQUEST, 3, units(0, 170, 85, 1)));
    add_row(op_row(crau_pkg::REQ_REQUEST, 4, ZERO_UNITS));
    add_row(op_row(crau_pkg::REQ_RELEASE, 3, ZERO_UNITS));
    add_row(chk_row(crau_pkg::REQ_REQUEST, 6, units(0, 0, 0, 2), 1'b0,
                    crau_pkg::ST_EXCEEDS_CLAIM, units(0, 170, 85, 1)));

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        settle_pool();
        write_totals(dir_table[i].op.amount);
      end else begin
        send_op(dir_table[i].op, dir_table[i].typed, dir_table[i].want);
      end
    end

    // Random phases, each under its own pool totals and starting from init.
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_pool();
      case (p)
        0: phase_totals = FULL_UNITS;
        1: phase_totals = ZERO_UNITS;
        2, 5: begin
          for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
            phase_totals[r] = crau_pkg::FIELD_W'($urandom_range(1, 12));
          end
        end
        4: phase_totals = units(255, 0, $urandom_range(255), $urandom_range(1, 20));
        default: begin
          for (int r = 0; r < crau_pkg::FIELD_RES; r++) begin
            phase_totals[r] = crau_pkg::FIELD_W'($urandom_range(255));
          end
        end
      endcase
      write_totals(phase_totals);
      op = draw_op();
      op.kind = crau_pkg::REQ_INIT;
      send_op(op, 1'b0, '0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        rnd_idx = p * ITEMS_PER_PHASE + n;
        if (rnd_idx < RAND_PHASES * ITEMS_PER_PHASE / 3) begin
          send_idle_pct = 22;
          recv_idle_pct = 66;
        end else if (rnd_idx < RAND_PHASES * ITEMS_PER_PHASE * 2 / 3) begin
          send_idle_pct = 66;
          recv_idle_pct = 22;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // The sender pauses once until every outcome is in.
        if (rnd_idx == SENDER_PAUSE_AT) settle_pool();
        // The receiver holds off once while the sender keeps offering.
        if (rnd_idx == RECV_HOLD_AT) hold_asked = 1'b1;
        send_op(draw_op(), 1'b0, '0);
      end
    end

    settle_pool();
    $display("Summary: %0d operations over %0d pool settings, %0d outcomes checked.",
             sent_cnt, RAND_PHASES + 3, checked_cnt);
    $display("Summary: %0d granted, %0d blocked, %0d over claim, %0d bad declare.",
             granted_cnt, status_cnt[crau_pkg::ST_BLOCKED],
             status_cnt[crau_pkg::ST_EXCEEDS_CLAIM],
             status_cnt[crau_pkg::ST_BAD_DECLARE]);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
